[sv/zigzag_varint_frame_encoder_macros.svh]
// assertion macros used by the encoder checker
`ifndef ZIGZAG_VARINT_FRAME_ENCODER_MACROS_SVH
`define ZIGZAG_VARINT_FRAME_ENCODER_MACROS_SVH

// implication checked outside reset
`define ZVFE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("zvfe check failed");

// next-cycle implication checked outside reset
`define ZVFE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("zvfe check failed");

// next-cycle implication checked at every edge, reset included
`define ZVFE_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("zvfe check failed");

`endif

[sv/zvfe_pkg.sv]
// types, constants and codes shared by the varint frame encoder
package zvfe_pkg;

    localparam int FRAME_BYTES = 256;
    localparam int POS_W = $clog2(FRAME_BYTES + 1);
    localparam logic [7:0] POS_SAT = 8'((FRAME_BYTES - 1) % 256);

    localparam logic [6:0] GROUP_MASK = 7'd127;
    localparam logic [7:0] CONT_BIT = 8'h80;

    typedef enum logic [1:0] {
        MODE_UNSIGNED = 2'd0,
        MODE_SIGNED   = 2'd1,
        MODE_RAW      = 2'd2,
        MODE_MARKER   = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode       mode;
        logic [31:0] value;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [7:0] position;
        logic       overflow;
        logic       last;
    } t_out;

    typedef struct packed {
        logic load;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic last;
    } t_sts;

endpackage

[sv/zvfe_ctrl.sv]
// control state machine: load an item, then emit its bytes one per free output slot
module zvfe_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  zvfe_pkg::t_sts i_sts,
    output zvfe_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd.load = 1'b0;
        o_cmd.emit = 1'b0;
        n_state    = r_state;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load = i_valid;
                if (i_valid) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_cmd.emit = i_sts.out_free;
                if (i_sts.out_free && i_sts.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[sv/zvfe_dpath.sv]
// datapath: operand shifter, frame position counter and output register
module zvfe_dpath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  zvfe_pkg::t_in  i_data,
    input  zvfe_pkg::t_cmd i_cmd,
    output zvfe_pkg::t_sts o_sts,
    input  logic           i_stall,
    output logic           o_valid,
    output zvfe_pkg::t_out o_data
);

    zvfe_pkg::t_mode             r_mode;
    logic [31:0]                 r_val;
    logic [1:0]                  r_cnt;
    logic [zvfe_pkg::POS_W-1:0]  r_wp;
    logic [zvfe_pkg::POS_W-1:0]  n_wp;
    logic                        r_out_valid;
    zvfe_pkg::t_out              r_out;

    logic [31:0]                 w_load_val;
    logic [31:0]                 w_shift;
    logic [7:0]                  w_byte;
    logic                        w_last;
    logic [zvfe_pkg::POS_W-1:0]  w_pos;
    logic                        w_ovf;

    always_comb begin
        if (i_data.mode == zvfe_pkg::MODE_SIGNED) begin
            w_load_val = {i_data.value[30:0], 1'b0} ^ {32{i_data.value[31]}};
        end else begin
            w_load_val = i_data.value;
        end
    end

    always_comb begin
        unique case (r_mode)
            zvfe_pkg::MODE_UNSIGNED, zvfe_pkg::MODE_SIGNED: begin
                w_last  = (r_val[31:7] == 25'd0);
                w_byte  = w_last ? r_val[7:0]
                                 : (zvfe_pkg::CONT_BIT | {1'b0, r_val[6:0] & zvfe_pkg::GROUP_MASK});
                w_shift = {7'd0, r_val[31:7]};
            end
            zvfe_pkg::MODE_RAW: begin
                w_last  = (r_cnt == 2'd3);
                w_byte  = r_val[7:0];
                w_shift = {8'd0, r_val[31:8]};
            end
            zvfe_pkg::MODE_MARKER: begin
                w_last  = 1'b1;
                w_byte  = r_val[7:0];
                w_shift = r_val;
            end
            default: begin
                w_last  = 1'b1;
                w_byte  = r_val[7:0];
                w_shift = r_val;
            end
        endcase
    end

    // marker restarts the frame at offset zero
    assign w_pos = (r_mode == zvfe_pkg::MODE_MARKER) ? '0 : r_wp;
    assign w_ovf = (w_pos >= zvfe_pkg::POS_W'(zvfe_pkg::FRAME_BYTES));
    assign n_wp  = w_ovf ? w_pos : (w_pos + zvfe_pkg::POS_W'(1));

    assign o_sts.out_free = !r_out_valid || !i_stall;
    assign o_sts.last     = w_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_data.mode;
            r_val  <= w_load_val;
            r_cnt  <= 2'd0;
        end else if (i_cmd.emit) begin
            r_val <= w_shift;
            r_cnt <= r_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_wp        <= n_wp;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.out_byte <= w_byte;
            r_out.position <= w_ovf ? zvfe_pkg::POS_SAT : 8'(w_pos);
            r_out.overflow <= w_ovf;
            r_out.last     <= w_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

[sv/zigzag_varint_frame_encoder.sv]
// top level of the zigzag varint frame encoder
// input channel: i_valid / o_stall carry one beat of mode and 32-bit value.
// output channel: o_valid / i_stall carry one encoded byte per beat with its
// frame position, an overflow flag and a last flag on the item's final byte.
// unsigned and signed modes give 1 to 5 bytes, raw mode 4, marker mode 1.
// an item is taken when the encoder is idle; it is loaded into the operand
// shifter, then its bytes enter the output register one byte per cycle
// while the output is not stalled. no new item is taken before the last
// byte is emitted, set by the single byte lane and output register.
// o_stall stays low while idle, even if a finished byte still waits in the
// output register, so the next beat is taken while that byte drains.
// a stalled output holds its byte; the encoder waits without losing data.
// reset (i_rst_n low, synchronous) empties the output register, returns the
// controller to idle and clears the frame position to zero.
// a marker byte always sits at position zero and restarts the frame; beyond
// the frame capacity bytes still flow with overflow set and position pinned.
module zigzag_varint_frame_encoder (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  zvfe_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output zvfe_pkg::t_out o_data
);

    zvfe_pkg::t_cmd w_cmd;
    zvfe_pkg::t_sts w_sts;

    zvfe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    zvfe_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (i_data),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

endmodule

[sv/zvfe_checker.sv]
// port-level checker for the varint frame encoder and its bind
`include "zigzag_varint_frame_encoder_macros.svh"

module zvfe_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input logic           o_stall,
    input zvfe_pkg::t_in  i_data,
    input logic           o_valid,
    input logic           i_stall,
    input zvfe_pkg::t_out o_data
);

    logic w_in_beat;
    assign w_in_beat = i_valid && !o_stall;

    `ZVFE_ASSERT_NXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_valid)
    `ZVFE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data))
    `ZVFE_ASSERT_IMP(a_ovf_pos, i_clk, i_rst_n, o_valid && o_data.overflow, o_data.position == zvfe_pkg::POS_SAT)
    `ZVFE_ASSERT_NXT(a_busy_after_beat, i_clk, i_rst_n, w_in_beat, o_stall)

endmodule

bind zigzag_varint_frame_encoder zvfe_checker u_zvfe_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
